@@ hw/rtl/dense_layer_sigmoid_forward_assert.svh @@
// Assertion macros for the dense layer block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef DENSE_LAYER_SIGMOID_FORWARD_ASSERT_SVH
`define DENSE_LAYER_SIGMOID_FORWARD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dls_pkg.sv @@
// Shared types, codes and the sigmoid table for the dense layer block.
// No dependencies; used by the interface users, the operand store and the top level.
package dls_pkg;

  localparam int unsigned InMaxDefault  = 64;
  localparam int unsigned OutMaxDefault = 32;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned FracW    = 12;

  localparam logic [CfgIdxW-1:0] CfgInSize  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOutSize = 1'b1;

  localparam logic [1:0] FuncLoadWeight = 2'd0;
  localparam logic [1:0] FuncLoadInput  = 2'd1;
  localparam logic [1:0] FuncRun        = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         in_index;
    logic [4:0]         out_index;
    logic signed [15:0] value;
  } item_t;

  typedef struct packed {
    logic [4:0]  neuron;
    logic [12:0] activation;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_LOOK,
    ST_MULF,
    ST_EMIT
  } state_e;

  typedef logic [256:0][12:0] sig_tab_t;

  // sigmoid(-8 + i/16) in Q1.12; upper half from an iterated exp(-1/16) in Q32.32
  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    tab;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] s;
    logic [63:0] lo;
    tab = '0;
    e   = 64'h1_0000_0000;
    for (int k = 0; k <= 128; k++) begin
      den = 64'h1_0000_0000 + e;
      num = (64'd1 << 44) + (den >> 1);
      // restoring long division; numerator stays below 2^46
      rem = '0;
      s   = '0;
      for (int b = 45; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          s[b] = 1'b1;
        end
      end
      lo           = 64'd4096 - s;
      tab[128 + k] = s[12:0];
      tab[128 - k] = lo[12:0];
      e            = (e * 64'd4034748382) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTab = build_sig_tab();

endpackage

@@ hw/rtl/dls_stream_if.sv @@
// Valid/ready channel carrying one payload per transfer.
// Payload type is set where the channel is instantiated; no package needed.
interface dls_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/dls_operand_store.sv @@
// Weight and input activation memories: one write and one registered read each.
// Depends on dls_pkg only for the parameter defaults.
module dls_operand_store #(
  parameter int unsigned IN_MAX  = dls_pkg::InMaxDefault,
  parameter int unsigned OUT_MAX = dls_pkg::OutMaxDefault,
  localparam int unsigned XAW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
  localparam int unsigned WAW = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1
) (
  input  logic               clk_i,
  input  logic               x_we_i,
  input  logic [XAW-1:0]     x_waddr_i,
  input  logic               w_we_i,
  input  logic [WAW-1:0]     w_waddr_i,
  input  logic signed [15:0] wdata_i,
  input  logic               rd_en_i,
  input  logic [XAW-1:0]     x_raddr_i,
  input  logic [WAW-1:0]     w_raddr_i,
  output logic signed [15:0] x_rdata_o,
  output logic signed [15:0] w_rdata_o
);
  import dls_pkg::*;

  logic signed [15:0] x_mem [IN_MAX];
  logic signed [15:0] w_mem [IN_MAX * OUT_MAX];
  logic signed [15:0] x_rd_q;
  logic signed [15:0] w_rd_q;

  always_ff @(posedge clk_i) begin
    if (x_we_i) begin
      x_mem[x_waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      x_rd_q <= x_mem[x_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      w_mem[w_waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      w_rd_q <= w_mem[w_raddr_i];
    end
  end

  assign x_rdata_o = x_rd_q;
  assign w_rdata_o = w_rd_q;

endmodule

@@ hw/rtl/dense_layer_sigmoid_forward.sv @@
// Fully connected layer with sigmoid output, Q4.12, one shared 16x16 multiplier.
// Load items are written to the store on transfer; the block is ready again on the next cycle.
// A run handles each neuron in turn: one MAC per cycle over the n active inputs through
// the registered memory reads, then drain, round, lookup, interpolate and emit.
// Results leave through an output register; a stalled sink holds the sequencer.
// Async active-low reset: in_size 64, out_size 32, idle; memories are not cleared.
module dense_layer_sigmoid_forward #(
  parameter int unsigned IN_MAX  = dls_pkg::InMaxDefault,
  parameter int unsigned OUT_MAX = dls_pkg::OutMaxDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dls_stream_if.sink                     item_i,
  dls_stream_if.source                   result_o,
  input  logic                           cfg_we_i,
  input  logic [dls_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [dls_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dls_pkg::*;

  `include "dense_layer_sigmoid_forward_assert.svh"

  localparam int unsigned XAW    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int unsigned WAW    = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1;
  localparam int unsigned NW     = $clog2(IN_MAX + 1);
  localparam int unsigned RunCap = (OUT_MAX < 32) ? OUT_MAX : 32;
  localparam int unsigned AccW   = 32 + $clog2(IN_MAX + 1);
  localparam int unsigned QW     = AccW + 1 - FracW;

  // configuration
  logic [6:0] in_size_q;
  logic [5:0] out_size_q;
  logic [NW-1:0] n_act;
  logic [5:0]    m_act;

  // sequencer
  state_e         state_q, state_d;
  logic [XAW-1:0] i_q, i_d;
  logic [4:0]     j_q, j_d;
  logic           rd_en;
  logic           rd_v_q;
  logic           mul_v_q;
  logic           acc_clr;
  logic           sig_mul;
  logic           out_load;
  logic           out_free;
  logic           is_last;

  // datapath
  item_t              item;
  logic               item_accept;
  logic               x_we, w_we;
  logic [XAW-1:0]     x_waddr;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic signed [15:0] x_rd, w_rd;
  logic signed [15:0] mul_a, mul_b;
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW:0]   rnd;
  logic signed [QW-1:0]   q_full;
  logic signed [15:0]     q_d, q_q;
  logic [15:0]        u;
  logic [8:0]         idx_hi;
  logic [12:0]        t0, t1, d_val;
  logic [12:0]        t0_q, d_q;
  logic [7:0]         f_q;
  logic [20:0]        interp;
  result_t            out_data_d, out_data_q;
  logic               out_valid_q;

  assign item        = item_i.data;
  assign item_accept = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_size_q  <= 7'd64;
      out_size_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgInSize:  in_size_q  <= cfg_data_i[6:0];
        CfgOutSize: out_size_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(in_size_q) > IN_MAX) n_act = NW'(IN_MAX);
    else                         n_act = NW'(in_size_q);
    if (32'(out_size_q) > RunCap) m_act = 6'(RunCap);
    else                          m_act = out_size_q;
  end

  // loads go straight into the store on transfer
  assign x_we    = item_accept && (item.func == FuncLoadInput) && (32'(item.in_index) < IN_MAX);
  assign w_we    = item_accept && (item.func == FuncLoadWeight) &&
                   (32'(item.in_index) < IN_MAX) && (32'(item.out_index) < OUT_MAX);
  assign x_waddr = XAW'(item.in_index);
  assign w_waddr = WAW'(32'(item.in_index) * OUT_MAX + 32'(item.out_index));
  assign w_raddr = WAW'(32'(i_q) * OUT_MAX + 32'(j_q));

  dls_operand_store #(
    .IN_MAX  (IN_MAX),
    .OUT_MAX (OUT_MAX)
  ) u_store (
    .clk_i     (clk_i),
    .x_we_i    (x_we),
    .x_waddr_i (x_waddr),
    .w_we_i    (w_we),
    .w_waddr_i (w_waddr),
    .wdata_i   (item.value),
    .rd_en_i   (rd_en),
    .x_raddr_i (i_q),
    .w_raddr_i (w_raddr),
    .x_rdata_o (x_rd),
    .w_rdata_o (w_rd)
  );

  assign out_free = !out_valid_q || result_o.ready;
  assign is_last  = ({1'b0, j_q} == (m_act - 6'd1));
  assign interp   = prod_q[20:0] + 21'd128;

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    rd_en      = 1'b0;
    acc_clr    = 1'b0;
    sig_mul    = 1'b0;
    out_load   = 1'b0;
    out_data_d.neuron     = j_q;
    out_data_d.activation = t0_q + 13'(interp >> 8);
    out_data_d.last       = is_last;
    case (state_q)
      ST_IDLE: begin
        if (item_accept && (item.func == FuncRun) && (m_act != 6'd0)) begin
          state_d = ST_MAC;
          i_d     = '0;
          j_d     = '0;
          acc_clr = 1'b1;
        end
      end
      ST_MAC: begin
        if (n_act == '0) begin
          state_d = ST_DRAIN;
        end else begin
          rd_en = 1'b1;
          if (NW'(i_q) == (n_act - NW'(1))) state_d = ST_DRAIN;
          else                              i_d = i_q + XAW'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !mul_v_q) state_d = ST_ROUND;
      end
      ST_ROUND: state_d = ST_LOOK;
      ST_LOOK:  state_d = ST_MULF;
      ST_MULF: begin
        sig_mul = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_MAC;
            j_d     = j_q + 5'd1;
            i_d     = '0;
            acc_clr = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      rd_v_q  <= rd_en;
      mul_v_q <= rd_v_q;
      if (acc_clr)      acc_q <= '0;
      else if (mul_v_q) acc_q <= acc_q + AccW'(prod_q);
      if (out_load)             out_valid_q <= 1'b1;
      else if (result_o.ready)  out_valid_q <= 1'b0;
    end
  end

  // shared multiplier: MAC operands, or slope times fraction for interpolation
  assign mul_a = sig_mul ? $signed({3'b000, d_q}) : x_rd;
  assign mul_b = sig_mul ? $signed({8'h00, f_q}) : w_rd;

  // round half up to Q4.12, floor via arithmetic shift, then saturate to [-8, 8)
  always_comb begin
    rnd    = {acc_q[AccW-1], acc_q} + (AccW + 1)'(2048);
    q_full = rnd[AccW:FracW];
    if (q_full > QW'(32767))       q_d = 16'sh7FFF;
    else if (q_full < QW'(-32768)) q_d = -16'sh8000;
    else                           q_d = q_full[15:0];
  end

  always_comb begin
    u      = {~q_q[15], q_q[14:0]};
    idx_hi = {1'b0, u[15:8]} + 9'd1;
    t0     = SigTab[u[15:8]];
    t1     = SigTab[idx_hi];
    d_val  = (t1 >= t0) ? (t1 - t0) : 13'd0;
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q || sig_mul) prod_q <= mul_a * mul_b;
    if (state_q == ST_ROUND) q_q <= q_d;
    if (state_q == ST_LOOK) begin
      t0_q <= t0;
      d_q  <= d_val;
      f_q  <= u[7:0];
    end
    if (out_load) out_data_q <= out_data_d;
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_data_q;

  `DLS_ASSERT_SAME(a_pipe_drained, clk_i, rst_ni,
    (state_q == ST_ROUND) || (state_q == ST_LOOK) || (state_q == ST_MULF) || (state_q == ST_EMIT),
    !rd_v_q && !mul_v_q, "MAC pipeline busy during sigmoid phase")
  `DLS_ASSERT_SAME(a_act_range, clk_i, rst_ni, result_o.valid,
    result_o.data.activation <= 13'd4096, "activation above one")
  `DLS_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_load && out_data_d.last,
    state_q == ST_IDLE, "sequencer not idle after last neuron")
  `DLS_ASSERT_NEXT(a_run_start, clk_i, rst_ni,
    item_accept && (item.func == FuncRun) && (m_act != 6'd0),
    (state_q == ST_MAC) && (i_q == '0) && (j_q == '0), "run did not start at neuron zero")

endmodule
